// ===== src/hdt_pkg.sv =====
`default_nettype none

package hdt_pkg;

    // Fixed-point resolution and CORDIC depth.
    localparam int FRAC_BITS         = 32;
    localparam int CORDIC_ITERATIONS = 32;

    // Port field widths.
    localparam int LAT_W    = 28;
    localparam int LNG_W    = 29;
    localparam int DIST_W   = 38;
    localparam int TIME_W   = 25;
    localparam int RADIUS_W = 23;
    localparam int SPEED_W  = 17;
    localparam int CFG_W    = RADIUS_W;
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 64;

    // Internal widths.
    localparam int UDEG_W  = 30;               // signed microdegree difference
    localparam int UMAG_W  = UDEG_W - 1;       // its magnitude
    localparam int ANG_W   = FRAC_BITS + 5;    // signed angle in Q(F)
    localparam int CW      = FRAC_BITS + 8;    // CORDIC x and y
    localparam int MAG_W   = FRAC_BITS + 2;    // operand magnitude of a product
    localparam int H_W     = FRAC_BITS + 1;    // h in [0, 1]
    localparam int ROOT_W  = FRAC_BITS + 1;    // floor square root of h * 2^F
    localparam int Z_W     = FRAC_BITS + 2;    // unsigned half central angle
    localparam int RK_W    = 37;               // radius * 10000
    localparam int RK_LO_W = 19;
    localparam int DEN_W   = 31;               // speed * 10000
    localparam int QT_W    = 26;               // travel time quotient bits

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_EARTH_RADIUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_SPEED = 1'd1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6378137;
    localparam logic [SPEED_W-1:0]  SPEED_RESET  = 17'd500;
    localparam int TENTHS_PER_M = 10000;

    // Pi in Q61 and the degree conversion constants.
    localparam logic [63:0] PI_Q61    = 64'h6487ED5110B4611A;
    localparam int          ANG_SHIFT = 61 - FRAC_BITS;
    localparam int          RCP_SHIFT = 40;
    localparam int          A_W       = 36;
    localparam int          B_W       = 29;
    localparam int          PA_W      = 66;
    localparam logic [63:0] D_HALF    = 64'd360000000;
    localparam logic [63:0] D_FULL    = 64'd180000000;
    localparam logic [63:0] A_HALF    = PI_Q61 / D_HALF;
    localparam logic [63:0] B_HALF    = PI_Q61 % D_HALF;
    localparam logic [63:0] A_FULL    = PI_Q61 / D_FULL;
    localparam logic [63:0] B_FULL    = PI_Q61 % D_FULL;
    localparam logic [127:0] R_HALF   = ({64'd0, B_HALF} << RCP_SHIFT) / {64'd0, D_HALF};
    localparam logic [127:0] R_FULL   = ({64'd0, B_FULL} << RCP_SHIFT) / {64'd0, D_FULL};

    typedef logic [CORDIC_ITERATIONS-1:0][ANG_W-1:0] atan_tab_t;

    // Restoring division on 128-bit values, used at elaboration only.
    function automatic logic [127:0] udiv128(input logic [127:0] x, input logic [127:0] d);
        logic [127:0] q;
        logic [127:0] r;
        q = '0;
        r = '0;
        for (int i = 127; i >= 0; i--) begin
            r = {r[126:0], x[i]};
            q = {q[126:0], 1'b0};
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // Floor square root of a 128-bit value.
    function automatic logic [63:0] usqrt128(input logic [127:0] x);
        logic [63:0]  res;
        logic [63:0]  cand;
        logic [127:0] sq;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            sq = 128'(cand) * 128'(cand);
            if (sq <= x) res = cand;
        end
        return res;
    endfunction

    // Right shift with rounding half up.
    function automatic logic [63:0] round_shr(input logic [127:0] x, input int s);
        logic [127:0] t;
        if (s == 0) return x[63:0];
        t = (x + (128'd1 << (s - 1))) >> s;
        return t[63:0];
    endfunction

    // Arctangent table from the Taylor series in Q62, rounded to Q(F).
    function automatic atan_tab_t build_atan();
        atan_tab_t    t;
        logic [127:0] sum;
        logic [127:0] term;
        int           e;
        t = '0;
        for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
            sum = '0;
            if (i == 0) begin
                sum = {64'd0, PI_Q61 >> 1};
            end else begin
                for (int k = 0; k < 32; k++) begin
                    e = 62 - i * (2 * k + 1);
                    if (e >= 0) begin
                        term = udiv128(128'd1 << e, 128'(2 * k + 1));
                        if ((k & 1) != 0) sum = sum - term;
                        else sum = sum + term;
                    end
                end
            end
            t[i] = ANG_W'(round_shr(sum, 62 - FRAC_BITS));
        end
        return t;
    endfunction

    // Reciprocal CORDIC gain from the product of 1/(1+4^-i) in Q62.
    function automatic logic [63:0] build_gain();
        logic [127:0] f;
        logic [127:0] q;
        f = 128'd1 << 62;
        for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
            if (2 * i <= 62) begin
                q = udiv128(f << 62, (128'd1 << 62) + (128'd1 << (62 - 2 * i)));
                f = {64'd0, q[63:0]};
            end
        end
        return round_shr({64'd0, usqrt128(f << 62)}, 62 - FRAC_BITS);
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan();
    localparam logic signed [CW-1:0] GAIN_INV = CW'(build_gain());
    localparam logic signed [ANG_W-1:0] PI_F =
        ANG_W'(round_shr({64'd0, PI_Q61}, 61 - FRAC_BITS));
    localparam logic signed [ANG_W-1:0] HALF_PI_F =
        ANG_W'(round_shr({64'd0, PI_Q61}, 62 - FRAC_BITS));
    localparam logic [H_W-1:0] ONE_F = H_W'(1) << FRAC_BITS;

    // Signed Q(F) product: magnitudes multiplied, rounded half up, sign restored.
    function automatic logic signed [CW-1:0] mulq(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic [MAG_W-1:0]   ma;
        logic [MAG_W-1:0]   mb;
        logic [2*MAG_W-1:0] p;
        logic [CW-1:0]      r;
        ma = MAG_W'((a < 0) ? -a : a);
        mb = MAG_W'((b < 0) ? -b : b);
        p = (2*MAG_W)'(ma) * (2*MAG_W)'(mb);
        p = (p + ((2*MAG_W)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        r = CW'(p);
        return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
    endfunction

endpackage

`default_nettype wire

// ===== src/haversine_distance_travel_time.sv =====
`default_nettype none

// Haversine great-circle distance and travel time between two positions given
// in signed microdegrees. Each item yields one result: the distance in units of
// 0.1 mm and the travel time, the distance in metres divided by the configured
// speed, both rounded to nearest. The unit is a single pipeline that takes a new
// item every clock cycle unless it stalls; its depth is set by the two 32-step
// CORDIC chains, the 33-step square root and the 26-step quotient of the travel
// time. When the result is not taken the whole pipeline holds and s_tready falls
// in the same cycle. The user writes radius and speed through the cfg port only
// while no item is in flight, unenforced here; a speed of zero counts as one.
module haversine_distance_travel_time import hdt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // first_latitude, first_longitude, second_latitude, second_longitude
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // distance_tenth_mm, travel_time
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic en;

    logic [RADIUS_W-1:0] radius_reg;
    logic [SPEED_W-1:0]  speed_reg;
    logic [RK_W-1:0]     rk_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W-1:0]    den_half_reg;
    logic [SPEED_W-1:0]  speed_eff;

    logic signed [LAT_W-1:0] first_latitude;
    logic signed [LNG_W-1:0] first_longitude;
    logic signed [LAT_W-1:0] second_latitude;
    logic signed [LNG_W-1:0] second_longitude;
    logic signed [UDEG_W-1:0] udeg [0:3];
    logic signed [ANG_W-1:0]  ang  [0:3];
    logic signed [CW-1:0]     trig [0:3];
    logic [3:0]               rad_v;
    logic [3:0]               trig_v;

    logic [3:1]               p_v_reg;
    logic signed [CW-1:0]     sa_reg [1:2];
    logic signed [CW-1:0]     sb_reg;
    logic signed [CW-1:0]     c12_reg;
    logic signed [CW-1:0]     t_reg;
    logic [H_W-1:0]           h_reg;
    logic signed [CW:0]       h_sum;

    logic                     sq_v;
    logic [ROOT_W-1:0]        root_h;
    logic [ROOT_W-1:0]        root_rest;
    logic                     vec_v;
    logic [Z_W-1:0]           z_half;

    logic [2:1]               d_v_reg;
    logic [Z_W+RK_LO_W:0]     lo_reg;
    logic [Z_W+RK_W-RK_LO_W:0] hi_reg;
    logic [DIST_W-1:0]        dist_reg;
    logic [Z_W+RK_W+1:0]      full;

    logic [DIST_W-1:0]        dist_out;
    logic [TIME_W-1:0]        time_out;

    // The whole pipeline advances unless a finished result is waiting.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Configuration registers and the scaled values derived from them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
            speed_reg  <= SPEED_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_EARTH_RADIUS: radius_reg <= cfg_data;
                REG_TRAVEL_SPEED: speed_reg  <= SPEED_W'(cfg_data);
                default: ;
            endcase
        end
    end

    assign speed_eff = (speed_reg == '0) ? SPEED_W'(1) : speed_reg;

    always_ff @(posedge aclk) begin
        rk_reg       <= RK_W'(radius_reg) * RK_W'(TENTHS_PER_M);
        den_reg      <= DEN_W'(speed_eff) * DEN_W'(TENTHS_PER_M);
        den_half_reg <= DEN_W'(speed_eff) * DEN_W'(TENTHS_PER_M / 2);
    end

    // Unpack the item and form the differences exactly in microdegrees.
    assign first_latitude   = s_tdata[LAT_W-1:0];
    assign first_longitude  = s_tdata[LAT_W+LNG_W-1:LAT_W];
    assign second_latitude  = s_tdata[2*LAT_W+LNG_W-1:LAT_W+LNG_W];
    assign second_longitude = s_tdata[2*LAT_W+2*LNG_W-1:2*LAT_W+LNG_W];

    assign udeg[0] = UDEG_W'(first_latitude) - UDEG_W'(second_latitude);
    assign udeg[1] = UDEG_W'(first_longitude) - UDEG_W'(second_longitude);
    assign udeg[2] = UDEG_W'(first_latitude);
    assign udeg[3] = UDEG_W'(second_latitude);

    // Two half-angle sines squared and two latitude cosines.
    for (genvar k = 0; k < 4; k++) begin : g_lane
        hdt_to_rad u_to_rad (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (s_tvalid),
            .half_mode (k < 2),
            .udeg      (udeg[k]),
            .out_valid (rad_v[k]),
            .angle     (ang[k])
        );

        hdt_trig u_trig (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (rad_v[k]),
            .cos_mode  (k >= 2),
            .angle     (ang[k]),
            .out_valid (trig_v[k]),
            .result    (trig[k])
        );
    end

    // h = sa + cos1 * cos2 * sb, clamped to [0, 1].
    assign h_sum = (CW+1)'(sa_reg[2]) + (CW+1)'(t_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg <= '0;
        end else if (en) begin
            p_v_reg <= {p_v_reg[2:1], &trig_v};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_reg[1] <= trig[0];
            sb_reg    <= trig[1];
            c12_reg   <= mulq(trig[2], trig[3]);
            sa_reg[2] <= sa_reg[1];
            t_reg     <= mulq(c12_reg, sb_reg);
            if (h_sum < 0) h_reg <= '0;
            else if (h_sum > (CW+1)'(ONE_F)) h_reg <= ONE_F;
            else h_reg <= H_W'(h_sum);
        end
    end

    hdt_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p_v_reg[3]),
        .h         (h_reg),
        .out_valid (sq_v),
        .root_h    (root_h),
        .root_rest (root_rest)
    );

    hdt_vec u_vec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_v),
        .y0        (root_h),
        .x0        (root_rest),
        .out_valid (vec_v),
        .z_out     (z_half)
    );

    // Distance: the full angle times radius * 10000, split into two products.
    assign full = (Z_W+RK_W+2)'(lo_reg) + ((Z_W+RK_W+2)'(hi_reg) << RK_LO_W);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg <= '0;
        end else if (en) begin
            d_v_reg <= {d_v_reg[1], vec_v};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg   <= (Z_W+RK_LO_W+1)'({z_half, 1'b0}) *
                        (Z_W+RK_LO_W+1)'(rk_reg[RK_LO_W-1:0]);
            hi_reg   <= (Z_W+RK_W-RK_LO_W+1)'({z_half, 1'b0}) *
                        (Z_W+RK_W-RK_LO_W+1)'(rk_reg[RK_W-1:RK_LO_W]);
            dist_reg <= DIST_W'((full + ((Z_W+RK_W+2)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
        end
    end

    // Travel time; its last stage is the output register.
    hdt_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_v_reg[2]),
        .dist_in   (dist_reg),
        .den       (den_reg),
        .den_half  (den_half_reg),
        .out_valid (m_tvalid),
        .dist_out  (dist_out),
        .time_out  (time_out)
    );

    assign m_tdata = M_DATA_W'({time_out, dist_out});

endmodule

`default_nettype wire

// ===== src/hdt_to_rad.sv =====
`default_nettype none

module hdt_to_rad import hdt_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic                     half_mode,
    input  logic signed [UDEG_W-1:0] udeg,
    output logic                     out_valid,
    output logic signed [ANG_W-1:0]  angle
);

    logic [4:1] v_reg;
    logic [3:1] neg_reg;
    logic [3:1] half_reg;

    logic [UMAG_W-1:0]  mag_reg;
    logic [PA_W-1:0]    pa_reg   [2:3];
    logic [UMAG_W-1:0]  q0_reg   [2:3];
    logic [UMAG_W+B_W-1:0] pb_reg [2:3];
    logic [UMAG_W+B_W-1:0] qd_reg;
    logic signed [ANG_W-1:0] angle_reg;

    logic [A_W-1:0]       a_sel;
    logic [B_W-1:0]       b_sel;
    logic [RCP_SHIFT-1:0] r_sel;
    logic [B_W-1:0]       d_sel3;
    logic [UMAG_W+RCP_SHIFT-1:0] pr;
    logic                 fix;
    logic [PA_W:0]        q_sum;
    logic [PA_W:0]        q_rnd;
    logic [ANG_W-1:0]     mag_ang;

    // Conversion constants for the half-angle or the full-angle divisor.
    always_comb begin
        a_sel  = half_reg[1] ? A_W'(A_HALF) : A_W'(A_FULL);
        b_sel  = half_reg[1] ? B_W'(B_HALF) : B_W'(B_FULL);
        r_sel  = half_reg[1] ? RCP_SHIFT'(R_HALF) : RCP_SHIFT'(R_FULL);
        d_sel3 = half_reg[3] ? B_W'(D_HALF) : B_W'(D_FULL);
        pr     = (UMAG_W+RCP_SHIFT)'(mag_reg) * (UMAG_W+RCP_SHIFT)'(r_sel);
    end

    // Quotient correction, rounding to Q(F) and sign.
    always_comb begin
        fix     = ((pb_reg[3] - qd_reg) >= (UMAG_W+B_W)'(d_sel3));
        q_sum   = (PA_W+1)'(pa_reg[3]) + (PA_W+1)'(q0_reg[3]) + (PA_W+1)'(fix);
        q_rnd   = (q_sum + ((PA_W+1)'(1) << (ANG_SHIFT - 1))) >> ANG_SHIFT;
        mag_ang = ANG_W'(q_rnd);
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:1], in_valid};
        end
    end

    // Magnitude, products by the quotient and remainder of pi over the divisor,
    // reciprocal estimate, back-multiplication and final correction.
    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg     <= UMAG_W'((udeg < 0) ? -udeg : udeg);
            neg_reg     <= {neg_reg[2:1], udeg < 0};
            half_reg    <= {half_reg[2:1], half_mode};
            pa_reg[2]   <= PA_W'(mag_reg) * PA_W'(a_sel);
            q0_reg[2]   <= UMAG_W'(pr >> RCP_SHIFT);
            pb_reg[2]   <= (UMAG_W+B_W)'(mag_reg) * (UMAG_W+B_W)'(b_sel);
            pa_reg[3]   <= pa_reg[2];
            q0_reg[3]   <= q0_reg[2];
            pb_reg[3]   <= pb_reg[2];
            qd_reg      <= (UMAG_W+B_W)'(q0_reg[2]) *
                           (UMAG_W+B_W)'(half_reg[2] ? B_W'(D_HALF) : B_W'(D_FULL));
            angle_reg   <= neg_reg[3] ? -$signed(mag_ang) : $signed(mag_ang);
        end
    end

    assign out_valid = v_reg[4];
    assign angle     = angle_reg;

endmodule

`default_nettype wire

// ===== src/hdt_trig.sv =====
`default_nettype none

module hdt_trig import hdt_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic                    cos_mode,
    input  logic signed [ANG_W-1:0] angle,
    output logic                    out_valid,
    output logic signed [CW-1:0]    result
);

    localparam int N = CORDIC_ITERATIONS;

    logic [N+1:0]            v_reg;
    logic [N:0]              mode_reg;
    logic [N:0]              neg_reg;
    logic signed [CW-1:0]    x_reg [0:N];
    logic signed [CW-1:0]    y_reg [0:N];
    logic signed [ANG_W-1:0] z_reg [0:N];
    logic signed [CW-1:0]    result_reg;

    logic signed [ANG_W-1:0] red;
    logic                    flip;

    // Reduce the angle into [-pi/2, pi/2] by steps of pi; cosine folds the sign first.
    always_comb begin
        red  = angle;
        flip = 1'b0;
        if (cos_mode) begin
            if (red < 0) red = -red;
            for (int k = 0; k < 2; k++) begin
                if (red > HALF_PI_F) begin
                    red  = red - PI_F;
                    flip = ~flip;
                end
            end
        end else begin
            for (int k = 0; k < 2; k++) begin
                if (red > HALF_PI_F) red = red - PI_F;
            end
            for (int k = 0; k < 2; k++) begin
                if (red < -HALF_PI_F) red = red + PI_F;
            end
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[N:0], in_valid};
        end
    end

    // Load the first stage and carry the mode flags.
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= GAIN_INV;
            y_reg[0]    <= '0;
            z_reg[0]    <= red;
            mode_reg    <= {mode_reg[N-1:0], cos_mode};
            neg_reg     <= {neg_reg[N-1:0], flip};
        end
    end

    // One rotation step per stage.
    for (genvar i = 0; i < N; i++) begin : g_rot
        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed(ATAN_TAB[i]);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed(ATAN_TAB[i]);
                end
            end
        end
    end

    // Cosine with its sign, or the rounded square of the sine.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (mode_reg[N]) begin
                result_reg <= neg_reg[N] ? -x_reg[N] : x_reg[N];
            end else begin
                result_reg <= mulq(y_reg[N], y_reg[N]);
            end
        end
    end

    assign out_valid = v_reg[N+1];
    assign result    = result_reg;

endmodule

`default_nettype wire

// ===== src/hdt_sqrt.sv =====
`default_nettype none

module hdt_sqrt import hdt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [H_W-1:0]    h,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root_h,
    output logic [ROOT_W-1:0] root_rest
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    // Lane 0 takes h, lane 1 takes one minus h; one root bit per stage.
    logic [ROOT_W:0]       v_reg;
    logic [RAD_W-1:0]      rad_reg  [0:1][0:ROOT_W];
    logic [REM_W-1:0]      rem_reg  [0:1][0:ROOT_W];
    logic [ROOT_W-1:0]     root_reg [0:1][0:ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[ROOT_W-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg[0][0]  <= RAD_W'(h) << FRAC_BITS;
            rad_reg[1][0]  <= RAD_W'(ONE_F - h) << FRAC_BITS;
            rem_reg[0][0]  <= '0;
            rem_reg[1][0]  <= '0;
            root_reg[0][0] <= '0;
            root_reg[1][0] <= '0;
        end
    end

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [REM_W+1:0] rem2;
            logic [REM_W+1:0] trial;

            always_comb begin
                rem2  = {rem_reg[l][j], rad_reg[l][j][RAD_W-1 -: 2]};
                trial = (REM_W+2)'({root_reg[l][j], 2'b01});
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[l][j+1] <= rad_reg[l][j] << 2;
                    if (rem2 >= trial) begin
                        rem_reg[l][j+1]  <= REM_W'(rem2 - trial);
                        root_reg[l][j+1] <= {root_reg[l][j][ROOT_W-2:0], 1'b1};
                    end else begin
                        rem_reg[l][j+1]  <= REM_W'(rem2);
                        root_reg[l][j+1] <= {root_reg[l][j][ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign out_valid = v_reg[ROOT_W];
    assign root_h    = root_reg[0][ROOT_W];
    assign root_rest = root_reg[1][ROOT_W];

endmodule

`default_nettype wire

// ===== src/hdt_vec.sv =====
`default_nettype none

module hdt_vec import hdt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [ROOT_W-1:0] y0,
    input  logic [ROOT_W-1:0] x0,
    output logic              out_valid,
    output logic [Z_W-1:0]    z_out
);

    localparam int N = CORDIC_ITERATIONS;

    logic [N+1:0]            v_reg;
    logic [N:0]              zero_reg;
    logic signed [CW-1:0]    x_reg [0:N];
    logic signed [CW-1:0]    y_reg [0:N];
    logic signed [ANG_W-1:0] z_reg [0:N];
    logic [Z_W-1:0]          z_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[N:0], in_valid};
        end
    end

    // A zero root of h means equal points and an angle of exactly zero.
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= $signed(CW'(x0));
            y_reg[0] <= $signed(CW'(y0));
            z_reg[0] <= '0;
            zero_reg <= {zero_reg[N-1:0], y0 == '0};
        end
    end

    // One vectoring step per stage drives y towards zero.
    for (genvar i = 0; i < N; i++) begin : g_vec
        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed(ATAN_TAB[i]);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed(ATAN_TAB[i]);
                end
            end
        end
    end

    // A slightly negative residue becomes zero.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (zero_reg[N] || z_reg[N] < 0) z_out_reg <= '0;
            else z_out_reg <= Z_W'(z_reg[N]);
        end
    end

    assign out_valid = v_reg[N+1];
    assign z_out     = z_out_reg;

endmodule

`default_nettype wire

// ===== src/hdt_divider.sv =====
`default_nettype none

module hdt_divider import hdt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DIST_W-1:0] dist_in,
    input  logic [DEN_W-1:0]  den,
    input  logic [DEN_W-1:0]  den_half,
    output logic              out_valid,
    output logic [DIST_W-1:0] dist_out,
    output logic [TIME_W-1:0] time_out
);

    localparam int NUM_W = DIST_W + 1;
    localparam int CMP_W = DEN_W + QT_W;

    logic [QT_W:0]       v_reg;
    logic [NUM_W-1:0]    rem_reg  [0:QT_W];
    logic [QT_W-1:0]     q_reg    [0:QT_W];
    logic [DIST_W-1:0]   dist_reg [0:QT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[QT_W-1:0], in_valid};
        end
    end

    // Add half the divisor so that the truncating quotient rounds to nearest.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= NUM_W'(dist_in) + NUM_W'(den_half);
            q_reg[0]    <= '0;
            dist_reg[0] <= dist_in;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 0; j < QT_W; j++) begin : g_div
        logic [CMP_W-1:0] dsh;
        logic             take;

        always_comb begin
            dsh  = CMP_W'(den) << (QT_W - 1 - j);
            take = (CMP_W'(rem_reg[j]) >= dsh);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1]  <= take ? NUM_W'(CMP_W'(rem_reg[j]) - dsh) : rem_reg[j];
                q_reg[j+1]    <= {q_reg[j][QT_W-2:0], take};
                dist_reg[j+1] <= dist_reg[j];
            end
        end
    end

    assign out_valid = v_reg[QT_W];
    assign dist_out  = dist_reg[QT_W];
    assign time_out  = TIME_W'(q_reg[QT_W]);

endmodule

`default_nettype wire
